>>> sv/frame_payload_locate_and_hash_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for frame_payload_locate_and_hash
// Concurrent check wrappers clocked on clk_i, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef FRAME_PAYLOAD_LOCATE_AND_HASH_MACROS_SVH
`define FRAME_PAYLOAD_LOCATE_AND_HASH_MACROS_SVH

// check while out of reset
`define FPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check at every edge, reset included
`define FPH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/fph_pkg.sv
// ----------------------------------------------------------------------------
// fph_pkg
// Shared types and constants of the frame payload locate and hash block.
// ----------------------------------------------------------------------------
package fph_pkg;

  localparam int MAX_FRAME_DEF   = 2048;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int FIELD_W = 12;
  localparam int HASH_W  = 64;
  localparam int START_W = 7;

  localparam logic [FIELD_W-1:0] MIN_LEN_RST = 12'd42;

  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_VER_IHL  = 14;
  localparam int POS_PROTO    = 14 + 9;
  localparam int POS_TCP_DOFF = 14 + 20 + 12;
  localparam int UDP_START    = 14 + 28;
  localparam int TCP_BASE     = 14 + 20;
  localparam int TCP_DOFF_MIN = 5;

  localparam logic [7:0] ETYPE_HI   = 8'h08;
  localparam logic [7:0] ETYPE_LO   = 8'h00;
  localparam logic [7:0] VER_IHL    = 8'h45;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SMALL = 3'd1,
    ST_NOT_IP    = 3'd2,
    ST_NOT_IPV4  = 3'd3,
    ST_OTHER     = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0]         data;
    logic               hash_en;
    logic               last;
    status_e            status;
    logic               tcp;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] off;
    logic [FIELD_W-1:0] plen;
  } fph_cmd_t;

endpackage

>>> sv/fph_queue.sv
// ----------------------------------------------------------------------------
// fph_queue
// Short command queue between the classifying front and the hashing back.
// ----------------------------------------------------------------------------
module fph_queue #(
  parameter int DEPTH = fph_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fph_pkg::fph_cmd_t push_cmd_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output fph_pkg::fph_cmd_t head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fph_pkg::fph_cmd_t  mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> sv/fph_front.sv
// ----------------------------------------------------------------------------
// fph_front
// Counts frame bytes, runs the header checks and builds one command per byte.
// ----------------------------------------------------------------------------
module fph_front #(
  parameter int MAX_FRAME = fph_pkg::MAX_FRAME_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fph_pkg::FIELD_W-1:0] min_len_i,
  input  logic                        push_i,
  input  logic [7:0]                  frame_byte_i,
  input  logic                        last_byte_i,
  output fph_pkg::fph_cmd_t           cmd_o
);

  localparam int CNT_W = $clog2(MAX_FRAME + 2);
  localparam int CMP_W = (CNT_W > fph_pkg::FIELD_W) ? CNT_W : fph_pkg::FIELD_W;
  localparam int SW    = fph_pkg::START_W;

  logic [CNT_W-1:0]     cnt_q, cnt_d, cnt_inc, len_sat;
  fph_pkg::status_e     early_q, early_d, status;
  logic                 tcp_q, tcp_d;
  logic [SW-1:0]        start_q, start_d;
  logic [CNT_W-1:0]     start_ext;
  logic [3:0]           doff;

  assign doff      = frame_byte_i[7:4];
  assign start_ext = CNT_W'(start_q);
  assign cnt_inc   = (cnt_q <= CNT_W'(MAX_FRAME)) ? cnt_q + 1'b1 : cnt_q;
  assign len_sat   = (cnt_inc > CNT_W'(MAX_FRAME)) ? CNT_W'(MAX_FRAME) : cnt_inc;

  always_comb begin
    early_d = early_q;
    tcp_d   = tcp_q;
    start_d = start_q;
    if (early_q == fph_pkg::ST_OK) begin
      if (cnt_q == CNT_W'(fph_pkg::POS_ETYPE_HI) && frame_byte_i != fph_pkg::ETYPE_HI) begin
        early_d = fph_pkg::ST_NOT_IP;
      end
      if (cnt_q == CNT_W'(fph_pkg::POS_ETYPE_LO) && frame_byte_i != fph_pkg::ETYPE_LO) begin
        early_d = fph_pkg::ST_NOT_IP;
      end
      if (cnt_q == CNT_W'(fph_pkg::POS_VER_IHL) && frame_byte_i != fph_pkg::VER_IHL) begin
        early_d = fph_pkg::ST_NOT_IPV4;
      end
      if (cnt_q == CNT_W'(fph_pkg::POS_PROTO)) begin
        if (frame_byte_i == fph_pkg::PROTO_TCP) begin
          tcp_d = 1'b1;
        end else if (frame_byte_i == fph_pkg::PROTO_UDP) begin
          tcp_d   = 1'b0;
          start_d = SW'(fph_pkg::UDP_START);
        end else begin
          early_d = fph_pkg::ST_OTHER;
        end
      end
      if (cnt_q == CNT_W'(fph_pkg::POS_TCP_DOFF) && tcp_q) begin
        if (doff < 4'(fph_pkg::TCP_DOFF_MIN)) begin
          early_d = fph_pkg::ST_MALFORMED;
        end else begin
          start_d = SW'(fph_pkg::TCP_BASE + 4 * int'(doff));
        end
      end
    end

    if (CMP_W'(cnt_inc) <= CMP_W'(min_len_i)) begin
      status = fph_pkg::ST_TOO_SMALL;
    end else if (cnt_inc > CNT_W'(MAX_FRAME)) begin
      status = fph_pkg::ST_TOO_LONG;
    end else if (early_d != fph_pkg::ST_OK) begin
      status = early_d;
    end else if (start_d == '0 || cnt_inc < CNT_W'(start_d)) begin
      status = fph_pkg::ST_MALFORMED;
    end else begin
      status = fph_pkg::ST_OK;
    end

    cmd_o.data    = frame_byte_i;
    cmd_o.hash_en = (early_q == fph_pkg::ST_OK) && (start_q != '0) &&
                    (cnt_q >= start_ext) && (cnt_q < CNT_W'(MAX_FRAME));
    cmd_o.last    = last_byte_i;
    cmd_o.status  = status;
    cmd_o.len     = fph_pkg::FIELD_W'(len_sat);
    if (status == fph_pkg::ST_OK) begin
      cmd_o.tcp  = tcp_d;
      cmd_o.off  = fph_pkg::FIELD_W'(start_d);
      cmd_o.plen = fph_pkg::FIELD_W'(cnt_inc - CNT_W'(start_d));
    end else begin
      cmd_o.tcp  = 1'b0;
      cmd_o.off  = '0;
      cmd_o.plen = '0;
    end

    cnt_d = cnt_inc;
    if (last_byte_i) begin
      cnt_d   = '0;
      early_d = fph_pkg::ST_OK;
      tcp_d   = 1'b0;
      start_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      early_q <= fph_pkg::ST_OK;
      tcp_q   <= 1'b0;
      start_q <= '0;
    end else if (push_i) begin
      cnt_q   <= cnt_d;
      early_q <= early_d;
      tcp_q   <= tcp_d;
      start_q <= start_d;
    end
  end

endmodule

>>> sv/fph_back.sv
// ----------------------------------------------------------------------------
// fph_back
// Runs the one-at-a-time hash over payload bytes, finalizes it at frame end
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module fph_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  fph_pkg::fph_cmd_t           cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic                        is_tcp_o,
  output logic [fph_pkg::FIELD_W-1:0] frame_length_o,
  output logic [fph_pkg::FIELD_W-1:0] payload_offset_o,
  output logic [fph_pkg::FIELD_W-1:0] payload_length_o,
  output logic [fph_pkg::HASH_W-1:0]  payload_hash_o
);

  localparam int HW = fph_pkg::HASH_W;

  logic [HW-1:0]     acc_q, acc_d, upd_a, upd_b, upd_c;
  logic              fin_valid_q;
  fph_pkg::fph_cmd_t fin_cmd_q;
  logic [HW-1:0]     fin_hash_q;
  logic [HW-1:0]     fz_a, fz_b, fz_c;
  logic              out_valid_q;
  fph_pkg::fph_cmd_t out_cmd_q;
  logic [HW-1:0]     out_hash_q;
  logic              out_adv, fin_free;

  assign out_adv   = !out_valid_q || out_ready_i;
  assign fin_free  = !fin_valid_q || out_adv;
  assign cmd_pop_o = cmd_valid_i && (!cmd_i.last || fin_free);

  always_comb begin
    upd_a = acc_q + HW'(cmd_i.data);
    upd_b = upd_a + (upd_a << 10);
    upd_c = upd_b ^ (upd_b >> 6);
    acc_d = cmd_i.hash_en ? upd_c : acc_q;
  end

  always_comb begin
    fz_a = fin_hash_q + (fin_hash_q << 3);
    fz_b = fz_a ^ (fz_a >> 11);
    fz_c = fz_b + (fz_b << 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        acc_q <= cmd_i.last ? '0 : acc_d;
      end
      if (cmd_pop_o && cmd_i.last) begin
        fin_valid_q <= 1'b1;
      end else if (out_adv) begin
        fin_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= fin_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.last) begin
      fin_cmd_q  <= cmd_i;
      fin_hash_q <= acc_d;
    end
    if (out_adv && fin_valid_q) begin
      out_cmd_q  <= fin_cmd_q;
      out_hash_q <= (fin_cmd_q.status == fph_pkg::ST_OK) ? fz_c : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_cmd_q.status;
  assign is_tcp_o         = out_cmd_q.tcp;
  assign frame_length_o   = out_cmd_q.len;
  assign payload_offset_o = out_cmd_q.off;
  assign payload_length_o = out_cmd_q.plen;
  assign payload_hash_o   = out_hash_q;

endmodule

>>> sv/frame_payload_locate_and_hash.sv
// The last byte's command passes the queue, the fin_* and out_* registers.
// Throughput: one frame byte per cycle; the front accepts while the queue has room.
// The byte rate is set by the hash update in the back; finalization is one extra
// register stage, so back-to-back frames stall input only when out_ready_i is low.
// Reset (rst_ni low, asynchronous): clears frame state, queue and output valid;
// min_frame_length returns to 42. No clearing pass.
// ----------------------------------------------------------------------------
// frame_payload_locate_and_hash
// Locates the TCP or UDP payload of an Ethernet/IPv4 frame and hashes it.
// ----------------------------------------------------------------------------
`include "frame_payload_locate_and_hash_macros.svh"

module frame_payload_locate_and_hash #(
  parameter int MAX_FRAME   = fph_pkg::MAX_FRAME_DEF,
  parameter int QUEUE_DEPTH = fph_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  frame_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic                        is_tcp_o,
  output logic [fph_pkg::FIELD_W-1:0] frame_length_o,
  output logic [fph_pkg::FIELD_W-1:0] payload_offset_o,
  output logic [fph_pkg::FIELD_W-1:0] payload_length_o,
  output logic [fph_pkg::HASH_W-1:0]  payload_hash_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [fph_pkg::FIELD_W-1:0] min_len_q;
  logic                        cfg_wr;
  logic                        push;
  logic                        q_ready, q_valid, q_pop;
  fph_pkg::fph_cmd_t           front_cmd, head_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(min_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= fph_pkg::MIN_LEN_RST;
    end else if (cfg_wr) begin
      min_len_q <= pwdata[fph_pkg::FIELD_W-1:0];
    end
  end

  assign in_ready_o = q_ready;
  assign push       = in_valid_i && q_ready;

  fph_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_len_i    (min_len_q),
    .push_i       (push),
    .frame_byte_i (frame_byte_i),
    .last_byte_i  (last_byte_i),
    .cmd_o        (front_cmd)
  );

  fph_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  fph_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (head_cmd),
    .cmd_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .is_tcp_o         (is_tcp_o),
    .frame_length_o   (frame_length_o),
    .payload_offset_o (payload_offset_o),
    .payload_length_o (payload_length_o),
    .payload_hash_o   (payload_hash_o)
  );

  `FPH_ASSERT(a_reject_zeroed, out_valid_o && status_o != fph_pkg::ST_OK |-> payload_hash_o == '0 && is_tcp_o == 1'b0 && payload_offset_o == '0, "rejected frame carries payload data")
  `FPH_ASSERT(a_len_sum, out_valid_o && status_o == fph_pkg::ST_OK |-> fph_pkg::FIELD_W'(payload_offset_o + payload_length_o) == frame_length_o, "offset plus length differs from frame length")
  `FPH_ASSERT(a_cfg_write, cfg_wr |=> min_len_q == $past(pwdata[fph_pkg::FIELD_W-1:0]), "min frame length write lost")

endmodule

>>> verif/frame_payload_locate_and_hash_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_payload_locate_and_hash_tb
// Streams Ethernet frames byte by byte into the block under random source and
// sink stalls, predicts the status, payload location and finalized payload hash
// of every frame, and checks each result against the prediction in order.
// ----------------------------------------------------------------------------
module frame_payload_locate_and_hash_tb;

  localparam int FRAME_CAP = fph_pkg::MAX_FRAME_DEF;
  localparam int RESULT_LATENCY = 3;
  localparam logic [2:0] ADDR_MIN_FRAME_LEN = 3'd0;

  typedef struct {
    fph_pkg::status_e                status;
    logic                            tcp;
    logic [fph_pkg::FIELD_W-1:0]     len;
    logic [fph_pkg::FIELD_W-1:0]     off;
    logic [fph_pkg::FIELD_W-1:0]     plen;
    logic [fph_pkg::HASH_W-1:0]      hash;
  } frame_result_t;

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_ready_o;
  logic [7:0]                      frame_byte_i = '0;
  logic                            last_byte_i  = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i  = 1'b0;
  logic [2:0]                      status_o;
  logic                            is_tcp_o;
  logic [fph_pkg::FIELD_W-1:0]     frame_length_o;
  logic [fph_pkg::FIELD_W-1:0]     payload_offset_o;
  logic [fph_pkg::FIELD_W-1:0]     payload_length_o;
  logic [fph_pkg::HASH_W-1:0]      payload_hash_o;
  logic                            psel         = 1'b0;
  logic                            penable      = 1'b0;
  logic                            pwrite       = 1'b0;
  logic [2:0]                      paddr        = '0;
  logic [31:0]                     pwdata       = '0;
  logic [31:0]                     prdata;
  logic                            pready;

  frame_result_t                   result_q[$];
  frame_result_t                   want;
  logic [7:0]                      frame_bytes[$];
  bit                              idle_on = 1'b1;
  int                              fail_count = 0;

  int                              frame_pos;
  logic [fph_pkg::HASH_W-1:0]      run_hash;
  fph_pkg::status_e                first_fault;
  bit                              saw_tcp;
  int                              payload_at;
  int                              min_len;

  frame_payload_locate_and_hash dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_byte_i     (frame_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .is_tcp_o         (is_tcp_o),
    .frame_length_o   (frame_length_o),
    .payload_offset_o (payload_offset_o),
    .payload_length_o (payload_length_o),
    .payload_hash_o   (payload_hash_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endfunction

  function automatic void clear_frame_state();
    frame_pos   = 0;
    run_hash    = '0;
    first_fault = fph_pkg::ST_OK;
    saw_tcp     = 1'b0;
    payload_at  = 0;
  endfunction

  function automatic void keep_first_fault(input fph_pkg::status_e code);
    if (first_fault == fph_pkg::ST_OK) begin
      first_fault = code;
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    frame_result_t              r;
    logic [fph_pkg::HASH_W-1:0] h;
    int                         flen;
    if (frame_pos == fph_pkg::POS_ETYPE_HI && b != fph_pkg::ETYPE_HI)
      keep_first_fault(fph_pkg::ST_NOT_IP);
    if (frame_pos == fph_pkg::POS_ETYPE_LO && b != fph_pkg::ETYPE_LO)
      keep_first_fault(fph_pkg::ST_NOT_IP);
    if (frame_pos == fph_pkg::POS_VER_IHL && b != fph_pkg::VER_IHL)
      keep_first_fault(fph_pkg::ST_NOT_IPV4);
    if (frame_pos == fph_pkg::POS_PROTO && first_fault == fph_pkg::ST_OK) begin
      if (b == fph_pkg::PROTO_TCP) begin
        saw_tcp = 1'b1;
      end else if (b == fph_pkg::PROTO_UDP) begin
        saw_tcp    = 1'b0;
        payload_at = fph_pkg::UDP_START;
      end else begin
        keep_first_fault(fph_pkg::ST_OTHER);
      end
    end
    if (frame_pos == fph_pkg::POS_TCP_DOFF && first_fault == fph_pkg::ST_OK && saw_tcp) begin
      if (int'(b[7:4]) < fph_pkg::TCP_DOFF_MIN) begin
        keep_first_fault(fph_pkg::ST_MALFORMED);
      end else begin
        payload_at = fph_pkg::TCP_BASE + 4 * int'(b[7:4]);
      end
    end
    if (first_fault == fph_pkg::ST_OK && payload_at != 0 && frame_pos >= payload_at &&
        frame_pos < FRAME_CAP) begin
      run_hash = run_hash + fph_pkg::HASH_W'(b);
      run_hash = run_hash + (run_hash << 10);
      run_hash = run_hash ^ (run_hash >> 6);
    end
    if (frame_pos <= FRAME_CAP) frame_pos++;
    if (!last) return;

    flen = frame_pos;
    if (flen <= min_len) r.status = fph_pkg::ST_TOO_SMALL;
    else if (flen > FRAME_CAP) r.status = fph_pkg::ST_TOO_LONG;
    else if (first_fault != fph_pkg::ST_OK) r.status = first_fault;
    else if (payload_at == 0 || flen < payload_at) r.status = fph_pkg::ST_MALFORMED;
    else r.status = fph_pkg::ST_OK;

    r.tcp  = 1'b0;
    r.off  = '0;
    r.plen = '0;
    r.hash = '0;
    if (r.status == fph_pkg::ST_OK) begin
      h = run_hash;
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      r.tcp  = saw_tcp;
      r.off  = fph_pkg::FIELD_W'(payload_at);
      r.plen = fph_pkg::FIELD_W'(flen - payload_at);
      r.hash = h;
    end
    r.len = fph_pkg::FIELD_W'((flen > FRAME_CAP) ? FRAME_CAP : flen);
    result_q.push_back(r);
    clear_frame_state();
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        flag_error($sformatf("unexpected result st=%0d len=%0d off=%0d plen=%0d hash=%h",
                             status_o, frame_length_o, payload_offset_o,
                             payload_length_o, payload_hash_o));
      end else begin
        want = result_q.pop_front();
        if (status_o !== want.status || is_tcp_o !== want.tcp ||
            frame_length_o !== want.len || payload_offset_o !== want.off ||
            payload_length_o !== want.plen || payload_hash_o !== want.hash) begin
          flag_error($sformatf(
            "mismatch exp st=%0d tcp=%0d len=%0d off=%0d plen=%0d hash=%h",
            want.status, want.tcp, want.len, want.off, want.plen, want.hash));
          if (fail_count <= 10) begin
            $display("         got st=%0d tcp=%0d len=%0d off=%0d plen=%0d hash=%h",
                     status_o, is_tcp_o, frame_length_o, payload_offset_o,
                     payload_length_o, payload_hash_o);
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    last_byte_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  task automatic set_min_frame_length(input int v);
    wait_for_results();
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MIN_FRAME_LEN;
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    min_len = v & ((1 << fph_pkg::FIELD_W) - 1);
  endtask

  function automatic void build_frame(input logic [7:0] proto, input int doff,
                                      input int plen);
    int hdr;
    hdr = fph_pkg::UDP_START;
    if (proto == fph_pkg::PROTO_TCP) begin
      hdr = (doff >= fph_pkg::TCP_DOFF_MIN) ? fph_pkg::TCP_BASE + 4 * doff :
                                              fph_pkg::POS_TCP_DOFF + 1;
    end
    frame_bytes.delete();
    repeat (hdr + plen) frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes[fph_pkg::POS_ETYPE_HI] = fph_pkg::ETYPE_HI;
    frame_bytes[fph_pkg::POS_ETYPE_LO] = fph_pkg::ETYPE_LO;
    frame_bytes[fph_pkg::POS_VER_IHL]  = fph_pkg::VER_IHL;
    frame_bytes[fph_pkg::POS_PROTO]    = proto;
    if (proto == fph_pkg::PROTO_TCP) begin
      frame_bytes[fph_pkg::POS_TCP_DOFF] = {4'(doff), 4'(frame_bytes[fph_pkg::POS_TCP_DOFF])};
    end
  endfunction

  function automatic void cut_frame(input int n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endfunction

  task automatic test_header_checks();
    build_frame(fph_pkg::PROTO_UDP, 0, 1);
    send_frame();
    build_frame(fph_pkg::PROTO_UDP, 0, 0);
    send_frame();
    build_frame(fph_pkg::PROTO_UDP, 0, 6);
    frame_bytes[fph_pkg::UDP_START]     = 8'h00;
    frame_bytes[fph_pkg::UDP_START + 1] = 8'hFF;
    frame_bytes[fph_pkg::UDP_START + 2] = 8'h80;
    frame_bytes[fph_pkg::UDP_START + 3] = 8'h01;
    send_frame();
    build_frame(fph_pkg::PROTO_UDP, 0, 5);
    frame_bytes[fph_pkg::POS_ETYPE_HI] = 8'h88;
    send_frame();
    build_frame(fph_pkg::PROTO_UDP, 0, 5);
    frame_bytes[fph_pkg::POS_ETYPE_LO] = 8'hDD;
    send_frame();
    build_frame(fph_pkg::PROTO_TCP, 5, 5);
    frame_bytes[fph_pkg::POS_VER_IHL] = 8'h46;
    send_frame();
    build_frame(8'h00, 0, 5);
    send_frame();
    build_frame(8'hFF, 0, 5);
    send_frame();
    build_frame(fph_pkg::PROTO_UDP, 0, 5);
    frame_bytes[fph_pkg::POS_ETYPE_LO] = 8'h01;
    frame_bytes[fph_pkg::POS_VER_IHL]  = 8'h60;
    send_frame();
  endtask

  task automatic test_tcp_offsets();
    build_frame(fph_pkg::PROTO_TCP, 5, 0);
    send_frame();
    build_frame(fph_pkg::PROTO_TCP, 15, 8);
    send_frame();
    build_frame(fph_pkg::PROTO_TCP, 4, 10);
    send_frame();
    build_frame(fph_pkg::PROTO_TCP, 0, 3);
    send_frame();
    build_frame(fph_pkg::PROTO_TCP, 9, 20);
    send_frame();
  endtask

  task automatic test_truncation();
    build_frame(fph_pkg::PROTO_TCP, 8, 10);
    cut_frame(fph_pkg::POS_TCP_DOFF - 1);
    send_frame();
    build_frame(fph_pkg::PROTO_TCP, 15, 5);
    cut_frame(80);
    send_frame();
    build_frame(fph_pkg::PROTO_UDP, 0, 10);
    frame_bytes[fph_pkg::POS_ETYPE_HI] = 8'h00;
    cut_frame(45);
    send_frame();
  endtask

  task automatic test_min_length_settings();
    set_min_frame_length(0);
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(255)));
    send_frame();
    build_frame(fph_pkg::PROTO_UDP, 0, 4);
    cut_frame(20);
    send_frame();
    build_frame(fph_pkg::PROTO_UDP, 0, 0);
    send_frame();
    build_frame(fph_pkg::PROTO_TCP, 6, 0);
    cut_frame(fph_pkg::POS_PROTO + 1);
    send_frame();
    set_min_frame_length(FRAME_CAP);
    build_frame(fph_pkg::PROTO_UDP, 0, 3);
    send_frame();
    set_min_frame_length(fph_pkg::MIN_LEN_RST);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (i % 2 == 0) build_frame(fph_pkg::PROTO_UDP, 0, $urandom_range(16));
      else build_frame(fph_pkg::PROTO_TCP, $urandom_range(15, 5), $urandom_range(16));
      send_frame();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int budget, input int min_frames);
    int         sent;
    int         frames;
    int         pick;
    int         doff;
    int         plen;
    logic [7:0] v;
    sent   = 0;
    frames = 0;
    while (sent < budget || frames < min_frames) begin
      pick = $urandom_range(99);
      doff = $urandom_range(15, 5);
      plen = ($urandom_range(19) == 0) ? $urandom_range(400) : $urandom_range(16);
      if (pick < 40) begin
        build_frame(fph_pkg::PROTO_UDP, 0, plen);
      end else if (pick < 75) begin
        build_frame(fph_pkg::PROTO_TCP, doff, plen);
      end else begin
        build_frame($urandom_range(1) ? fph_pkg::PROTO_TCP : fph_pkg::PROTO_UDP, doff, plen);
        case ($urandom_range(6))
          0: frame_bytes[fph_pkg::POS_ETYPE_HI] =
               frame_bytes[fph_pkg::POS_ETYPE_HI] ^ 8'($urandom_range(255, 1));
          1: frame_bytes[fph_pkg::POS_ETYPE_LO] =
               frame_bytes[fph_pkg::POS_ETYPE_LO] ^ 8'($urandom_range(255, 1));
          2: frame_bytes[fph_pkg::POS_VER_IHL] =
               frame_bytes[fph_pkg::POS_VER_IHL] ^ 8'($urandom_range(255, 1));
          3: begin
            do v = 8'($urandom_range(255));
            while (v == fph_pkg::PROTO_TCP || v == fph_pkg::PROTO_UDP);
            frame_bytes[fph_pkg::POS_PROTO] = v;
          end
          4: begin
            v = frame_bytes[fph_pkg::POS_TCP_DOFF];
            frame_bytes[fph_pkg::POS_TCP_DOFF] = {4'($urandom_range(4)), v[3:0]};
          end
          5: cut_frame($urandom_range(frame_bytes.size() - 1, 1));
          default: begin
            frame_bytes.delete();
            repeat ($urandom_range(70, 1)) frame_bytes.push_back(8'($urandom_range(255)));
          end
        endcase
      end
      if (frames == 2 || $urandom_range(31) == 0) wait_for_results();
      send_frame();
      sent += frame_bytes.size();
      frames++;
    end
  endtask

  initial begin
    min_len = fph_pkg::MIN_LEN_RST;
    clear_frame_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_checks();
    test_tcp_offsets();
    test_truncation();
    test_min_length_settings();
    test_back_to_back();
    test_random_traffic(250, 3);
    set_min_frame_length($urandom_range(60));
    test_random_traffic(150, 2);

    wait_for_results();
    repeat (RESULT_LATENCY + 5) @(posedge clk_i);
    if (result_q.size() != 0) flag_error("results still pending at end of run");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
